>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks used by the controller unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// invariant checked on every clock edge outside reset
`define ASSERT_INV(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

>>> rtl/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// PID position controller package
// Widths, constants and register indexes shared by the controller files.
// ----------------------------------------------------------------------------
package pidpc_pkg;

    localparam int unsigned FRAC_BITS        = 16;
    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned TICKS_W          = $clog2(TICKS_PER_SECOND);

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MUL_W     = DATA_W + 1;      // magnitude operand width
    localparam int unsigned PROD_W    = 2 * MUL_W;
    localparam int unsigned DIVN_W    = 2 * DATA_W;      // dividend / quotient
    localparam int unsigned DIVD_W    = DATA_W;          // divisor / remainder
    localparam int unsigned MUL_CNT_W = $clog2(MUL_W);
    localparam int unsigned DIV_CNT_W = $clog2(DIVN_W);

    localparam logic [MUL_CNT_W-1:0] MUL_LAST  = MUL_CNT_W'(MUL_W - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIVN_W - 1);
    localparam logic [MUL_W-1:0]     TICKS_MUL = MUL_W'(TICKS_PER_SECOND);
    localparam logic [DIVD_W-1:0]    TICKS_DIV = DIVD_W'(TICKS_PER_SECOND);

    typedef logic [7:0] t_cfg_index;

    localparam t_cfg_index CFG_SETPOINT = 8'd0;
    localparam t_cfg_index CFG_GAIN_P   = 8'd1;
    localparam t_cfg_index CFG_GAIN_D   = 8'd2;
    localparam t_cfg_index CFG_GAIN_I   = 8'd3;

    localparam logic [DATA_W-1:0] SETPOINT_RESET = 32'd1000;

endpackage

>>> rtl/pidpc_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Unsigned shift-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidpc_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pidpc_pkg::MUL_W-1:0]   i_a,
    input  logic [pidpc_pkg::MUL_W-1:0]   i_b,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [pidpc_pkg::PROD_W-1:0]  o_prod
);

    logic [pidpc_pkg::MUL_W-1:0]     r_a;
    logic [pidpc_pkg::MUL_W-1:0]     r_hi;
    logic [pidpc_pkg::MUL_W-1:0]     r_lo;
    logic [pidpc_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [pidpc_pkg::MUL_W:0]       w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
            end else if (r_busy) begin
                // low half shifts out multiplier bits, takes in product bits
                r_hi  <= w_sum[pidpc_pkg::MUL_W:1];
                r_lo  <= {w_sum[0], r_lo[pidpc_pkg::MUL_W-1:1]};
                r_cnt <= r_cnt + pidpc_pkg::MUL_CNT_W'(1);
                if (r_cnt == pidpc_pkg::MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

>>> rtl/pidpc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Unsigned restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidpc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pidpc_pkg::DIVN_W-1:0]  i_num,
    input  logic [pidpc_pkg::DIVD_W-1:0]  i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [pidpc_pkg::DIVN_W-1:0]  o_quo,
    output logic [pidpc_pkg::DIVD_W-1:0]  o_rem
);

    logic [pidpc_pkg::DIVD_W-1:0]    r_den;
    logic [pidpc_pkg::DIVD_W-1:0]    r_rem;
    logic [pidpc_pkg::DIVN_W-1:0]    r_quo;
    logic [pidpc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [pidpc_pkg::DIVD_W:0]      w_trial;
    logic [pidpc_pkg::DIVD_W:0]      w_diff;
    logic                            w_take;

    assign w_trial = {r_rem, r_quo[pidpc_pkg::DIVN_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    // trial < 2*den, so a borrow always lands in the top bit
    assign w_take  = ~w_diff[pidpc_pkg::DIVD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= w_take ? w_diff[pidpc_pkg::DIVD_W-1:0]
                                : w_trial[pidpc_pkg::DIVD_W-1:0];
                r_quo <= {r_quo[pidpc_pkg::DIVN_W-2:0], w_take};
                r_cnt <= r_cnt + pidpc_pkg::DIV_CNT_W'(1);
                if (r_cnt == pidpc_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/pid_position_controller_unit.sv
// ----------------------------------------------------------------------------
// PID position controller
// Fixed-point PID on encoder position with a variable, timestamped step.
//
// Input channel (valid/stall): one word is a position and a microsecond
// timestamp. Output channel (valid/stall): one word per input, the saturated
// drive and a flag that is set when any term or the drive was clipped.
// Config channel (valid/ready, always ready): index 0 setpoint, 1..3 the
// Q16.16 gains P, D, I; other indexes are dropped. Write only while idle.
// Each word runs through one bit-serial multiplier and one bit-serial
// divider: six products and three quotients, or two quotients when the
// timestamp repeats. The input stalls from accept until the result is
// registered.
// Result sits in an output register; the next word is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds until the old word is taken.
// Reset: setpoint 1000, gains 0, time, last error and integral cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_position_controller_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_position,
    input  logic        [31:0] i_timestamp_us,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_drive,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_NUM,
        ST_DIV_DER,
        ST_MUL_INT,
        ST_INT_ADD,
        ST_INT_DIV,
        ST_DIV_INT,
        ST_MUL_P,
        ST_MUL_D,
        ST_ADD_D,
        ST_MUL_Q,
        ST_ADD_Q,
        ST_MUL_R,
        ST_DIV_R,
        ST_ADD_R,
        ST_FINAL
    } t_state;

    function automatic logic [32:0] f_mag33(input logic [31:0] v);
        logic [32:0] s;
        s = {v[31], v};
        return v[31] ? (~s + 33'd1) : s;
    endfunction

    function automatic logic [63:0] f_mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] f_neg64(input logic neg, input logic [63:0] mag);
        return neg ? (~mag + 64'd1) : mag;
    endfunction

    // {clipped, sum}
    function automatic logic [64:0] f_sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        logic        ovf;
        s   = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (ovf) begin
            return {1'b1, a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        end
        return {1'b0, s};
    endfunction

    // signed value from sign and magnitude, clipped to 32 bits: {clipped, value}
    function automatic logic [32:0] f_clip_mag(input logic neg, input logic [63:0] mag);
        if (!neg) begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                return {1'b1, 32'h7FFF_FFFF};
            end
            return {1'b0, mag[31:0]};
        end
        if (mag > 64'h0000_0000_8000_0000) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, ~mag[31:0] + 32'd1};
    endfunction

    t_state r_state;

    // configuration and loop state
    logic [31:0] r_setpoint;
    logic [31:0] r_kp;
    logic [31:0] r_kd;
    logic [31:0] r_ki;
    logic [31:0] r_last_time;
    logic [31:0] r_last_error;
    logic [63:0] r_integral;

    // per-word working registers
    logic [31:0]                     r_e;
    logic [31:0]                     r_elapsed;
    logic [31:0]                     r_deriv;
    logic [31:0]                     r_q;
    logic [pidpc_pkg::TICKS_W-1:0]   r_rmag;
    logic                            r_rneg;
    logic                            r_neg;
    logic [63:0]                     r_term;
    logic [63:0]                     r_sum;
    logic                            r_flag;

    // serial unit launch
    logic                            r_mul_start;
    logic [pidpc_pkg::MUL_W-1:0]     r_mul_a;
    logic [pidpc_pkg::MUL_W-1:0]     r_mul_b;
    logic                            r_div_start;
    logic [pidpc_pkg::DIVN_W-1:0]    r_div_n;
    logic [pidpc_pkg::DIVD_W-1:0]    r_div_d;

    // output word
    logic                            r_out_valid;
    logic [31:0]                     r_drive;
    logic                            r_sat;

    logic                            w_mul_busy;
    logic                            w_mul_done;
    logic [pidpc_pkg::PROD_W-1:0]    w_prod;
    logic                            w_div_busy;
    logic                            w_div_done;
    logic [pidpc_pkg::DIVN_W-1:0]    w_quo;
    logic [pidpc_pkg::DIVD_W-1:0]    w_rem;

    logic [32:0] w_pos_err;
    logic        w_e_ovf;
    logic [31:0] w_e_val;
    logic [32:0] w_dd;
    logic [32:0] w_dd_mag;
    logic [32:0] w_qclip;
    logic [63:0] w_add_a;
    logic [64:0] w_sadd;
    logic        w_drive_clip;
    logic [31:0] w_drive;
    logic [63:0] w_prod64;

    pidpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pidpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_n),
        .i_den   (r_div_d),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // position error, clipped to 32 bits
    assign w_pos_err = {i_position[31], i_position} - {r_setpoint[31], r_setpoint};
    assign w_e_ovf   = w_pos_err[32] != w_pos_err[31];
    assign w_e_val   = w_e_ovf ? (w_pos_err[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                               : w_pos_err[31:0];

    assign w_dd     = {r_e[31], r_e} - {r_last_error[31], r_last_error};
    assign w_dd_mag = w_dd[32] ? (~w_dd + 33'd1) : w_dd;

    assign w_qclip  = f_clip_mag(r_neg, w_quo);
    assign w_prod64 = w_prod[63:0];

    // one saturating adder shared by the integral and the output sum
    assign w_add_a = (r_state == ST_INT_ADD) ? r_integral : r_sum;
    assign w_sadd  = f_sat_add(w_add_a, r_term);

    // floor shift is a plain drop of the fraction bits
    assign w_drive_clip = !((&r_sum[63:pidpc_pkg::FRAC_BITS+31])
                         || (~|r_sum[63:pidpc_pkg::FRAC_BITS+31]));
    assign w_drive = w_drive_clip ? (r_sum[63] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                  : r_sum[pidpc_pkg::FRAC_BITS+31:pidpc_pkg::FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_setpoint   <= pidpc_pkg::SETPOINT_RESET;
            r_kp         <= '0;
            r_kd         <= '0;
            r_ki         <= '0;
            r_last_time  <= '0;
            r_last_error <= '0;
            r_integral   <= '0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pidpc_pkg::CFG_SETPOINT: r_setpoint <= i_cfg_data;
                    pidpc_pkg::CFG_GAIN_P:   r_kp       <= i_cfg_data;
                    pidpc_pkg::CFG_GAIN_D:   r_kd       <= i_cfg_data;
                    pidpc_pkg::CFG_GAIN_I:   r_ki       <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_e         <= w_e_val;
                        r_flag      <= w_e_ovf;
                        r_elapsed   <= i_timestamp_us - r_last_time;
                        r_last_time <= i_timestamp_us;
                        r_state     <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_mul_a     <= w_dd_mag;
                    r_mul_b     <= pidpc_pkg::TICKS_MUL;
                    r_mul_start <= 1'b1;
                    r_neg       <= w_dd[32];
                    r_state     <= ST_MUL_NUM;
                end
                ST_MUL_NUM: begin
                    if (w_mul_done) begin
                        if (r_elapsed == '0) begin
                            // no time passed: derivative zero, integral term zero
                            r_deriv     <= '0;
                            r_mul_a     <= f_mag33(r_e);
                            r_mul_b     <= {1'b0, r_elapsed};
                            r_mul_start <= 1'b1;
                            r_neg       <= r_e[31];
                            r_state     <= ST_MUL_INT;
                        end else begin
                            r_div_n     <= w_prod64;
                            r_div_d     <= r_elapsed;
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV_DER;
                        end
                    end
                end
                ST_DIV_DER: begin
                    if (w_div_done) begin
                        r_deriv     <= w_qclip[31:0];
                        r_flag      <= r_flag | w_qclip[32];
                        r_mul_a     <= f_mag33(r_e);
                        r_mul_b     <= {1'b0, r_elapsed};
                        r_mul_start <= 1'b1;
                        r_neg       <= r_e[31];
                        r_state     <= ST_MUL_INT;
                    end
                end
                ST_MUL_INT: begin
                    if (w_mul_done) begin
                        r_term  <= f_neg64(r_neg, w_prod64);
                        r_state <= ST_INT_ADD;
                    end
                end
                ST_INT_ADD: begin
                    r_integral <= w_sadd[63:0];
                    r_flag     <= r_flag | w_sadd[64];
                    r_state    <= ST_INT_DIV;
                end
                ST_INT_DIV: begin
                    r_div_n     <= f_mag64(r_integral);
                    r_div_d     <= pidpc_pkg::TICKS_DIV;
                    r_div_start <= 1'b1;
                    r_neg       <= r_integral[63];
                    r_state     <= ST_DIV_INT;
                end
                ST_DIV_INT: begin
                    if (w_div_done) begin
                        r_q         <= w_qclip[31:0];
                        r_flag      <= r_flag | w_qclip[32];
                        r_rmag      <= w_rem[pidpc_pkg::TICKS_W-1:0];
                        r_rneg      <= r_neg;
                        r_mul_a     <= f_mag33(r_kp);
                        r_mul_b     <= f_mag33(r_e);
                        r_mul_start <= 1'b1;
                        r_neg       <= r_kp[31] ^ r_e[31];
                        r_state     <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    if (w_mul_done) begin
                        // kp*e cannot overflow 64 bits, no saturation needed
                        r_sum       <= f_neg64(r_neg, w_prod64);
                        r_mul_a     <= f_mag33(r_kd);
                        r_mul_b     <= f_mag33(r_deriv);
                        r_mul_start <= 1'b1;
                        r_neg       <= r_kd[31] ^ r_deriv[31];
                        r_state     <= ST_MUL_D;
                    end
                end
                ST_MUL_D: begin
                    if (w_mul_done) begin
                        r_term  <= f_neg64(r_neg, w_prod64);
                        r_state <= ST_ADD_D;
                    end
                end
                ST_ADD_D: begin
                    r_sum       <= w_sadd[63:0];
                    r_flag      <= r_flag | w_sadd[64];
                    r_mul_a     <= f_mag33(r_ki);
                    r_mul_b     <= f_mag33(r_q);
                    r_mul_start <= 1'b1;
                    r_neg       <= r_ki[31] ^ r_q[31];
                    r_state     <= ST_MUL_Q;
                end
                ST_MUL_Q: begin
                    if (w_mul_done) begin
                        r_term  <= f_neg64(r_neg, w_prod64);
                        r_state <= ST_ADD_Q;
                    end
                end
                ST_ADD_Q: begin
                    r_sum       <= w_sadd[63:0];
                    r_flag      <= r_flag | w_sadd[64];
                    r_mul_a     <= f_mag33(r_ki);
                    r_mul_b     <= pidpc_pkg::MUL_W'(r_rmag);
                    r_mul_start <= 1'b1;
                    r_neg       <= r_ki[31] ^ r_rneg;
                    r_state     <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    if (w_mul_done) begin
                        // remainder term, truncated toward zero
                        r_div_n     <= w_prod64;
                        r_div_d     <= pidpc_pkg::TICKS_DIV;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_R;
                    end
                end
                ST_DIV_R: begin
                    if (w_div_done) begin
                        r_term  <= f_neg64(r_neg, w_quo);
                        r_state <= ST_ADD_R;
                    end
                end
                ST_ADD_R: begin
                    r_sum   <= w_sadd[63:0];
                    r_flag  <= r_flag | w_sadd[64];
                    r_state <= ST_FINAL;
                end
                ST_FINAL: begin
                    // hold while the previous word still waits at the output
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_drive      <= w_drive;
                        r_sat        <= r_flag | w_drive_clip;
                        r_last_error <= r_e;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;
    assign o_cfg_ready = 1'b1;

    `ASSERT_IMPL(a_accept_starts_word, i_in_valid && !o_in_stall, ##1 (r_state == ST_DIFF), "accepted word did not start the sequence")
    `ASSERT_IMPL(a_final_holds, (r_state == ST_FINAL) && r_out_valid && i_out_stall, ##1 (r_state == ST_FINAL), "result overwrote a word still waiting")
    `ASSERT_INV(a_one_unit_busy, $onehot0({w_mul_busy, w_div_busy}), "multiplier and divider busy together")
    `ASSERT_IMPL(a_div_nonzero, r_div_start, r_div_d != '0, "divider launched with zero divisor")

endmodule
